### rtl/clipped_line_rasterizer_top_assert.svh
// Assertion macros shared by the rasterizer RTL.
// Each macro expects clk and rst_n in the enclosing scope.
`ifndef CLIPPED_LINE_RASTERIZER_TOP_ASSERT_SVH
`define CLIPPED_LINE_RASTERIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define CLR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define CLR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define CLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CLR_ASSERT(lbl, prop)
`define CLR_ASSERT_IMPL(lbl, ante, cons)
`define CLR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/clr_pkg.sv
`default_nettype none

package clr_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int EXT_WIDTH   = COORD_WIDTH + 1;
  localparam int ERR_WIDTH   = COORD_WIDTH + 3;
  localparam int CLIP_WIDTH  = 12;
  localparam int OFS_WIDTH   = 24;
  localparam int COLOR_WIDTH = 16;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
  localparam logic [1:0] REG_CLIP_TOP    = 2'd1;
  localparam logic [1:0] REG_CLIP_RIGHT  = 2'd2;
  localparam logic [1:0] REG_CLIP_BOTTOM = 2'd3;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_REJECT = 2'd1,
    ST_PIXEL  = 2'd2,
    ST_IDLE   = 2'd3
  } status_t;

  typedef struct packed {
    logic                          req_type;
    logic signed [COORD_WIDTH-1:0] x_start;
    logic signed [COORD_WIDTH-1:0] y_start;
    logic signed [COORD_WIDTH-1:0] x_end;
    logic signed [COORD_WIDTH-1:0] y_end;
    logic [COLOR_WIDTH-1:0]        line_color;
  } in_item_t;

  typedef struct packed {
    status_t                       status;
    logic signed [COORD_WIDTH-1:0] pixel_x;
    logic signed [COORD_WIDTH-1:0] pixel_y;
    logic [OFS_WIDTH-1:0]          pixel_offset;
    logic [COLOR_WIDTH-1:0]        pixel_color;
    logic                          write_enable;
    logic                          last;
  } out_item_t;

  typedef struct packed {
    logic [CLIP_WIDTH-1:0] left;
    logic [CLIP_WIDTH-1:0] top;
    logic [CLIP_WIDTH-1:0] right;
    logic [CLIP_WIDTH-1:0] bottom;
  } clip_t;

  // result of the line engine, before the frame buffer offset is formed
  typedef struct packed {
    status_t                       status;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic [COLOR_WIDTH-1:0]        color;
    logic                          in_clip;
    logic                          fin;
  } part_t;

endpackage

`default_nettype wire

### rtl/clr_engine.sv
`default_nettype none
`include "clipped_line_rasterizer_top_assert.svh"

module clr_engine import clr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  in_item_t item,
  input  clip_t    clip,
  output part_t    part
);

  logic                          busy_r;
  logic signed [COORD_WIDTH-1:0] major_pos_r, minor_pos_r, major_end_r;
  logic [COORD_WIDTH-1:0]        major_delta_r;
  logic [COORD_WIDTH:0]          minor_delta_twice_r;
  logic signed [ERR_WIDTH-1:0]   error_acc_r;
  logic                          major_dir_neg_r, minor_dir_neg_r, axis_swapped_r;
  logic [COLOR_WIDTH-1:0]        held_color_r;

  logic signed [EXT_WIDTH-1:0] x1, y1, x2, y2, dx, dy, dx_mag, dy_mag;
  logic signed [EXT_WIDTH-1:0] bx1, bx2, by1, by2, cl, ct, cr, cb, pxe, pye;
  logic [COORD_WIDTH-1:0]      adx, ady;
  logic                        xneg, yneg, reject, x_major;
  logic signed [COORD_WIDTH-1:0] px, py;
  logic                        in_clip, fin, minor_move;
  logic signed [ERR_WIDTH-1:0] err_sum, delta_ext, error_acc_nxt;
  logic signed [COORD_WIDTH-1:0] major_pos_nxt, minor_pos_nxt;

  assign x1 = EXT_WIDTH'(item.x_start);
  assign y1 = EXT_WIDTH'(item.y_start);
  assign x2 = EXT_WIDTH'(item.x_end);
  assign y2 = EXT_WIDTH'(item.y_end);
  assign cl = $signed({{(EXT_WIDTH-CLIP_WIDTH){1'b0}}, clip.left});
  assign ct = $signed({{(EXT_WIDTH-CLIP_WIDTH){1'b0}}, clip.top});
  assign cr = $signed({{(EXT_WIDTH-CLIP_WIDTH){1'b0}}, clip.right});
  assign cb = $signed({{(EXT_WIDTH-CLIP_WIDTH){1'b0}}, clip.bottom});

  // start: bounding box test and axis selection
  assign bx1    = (x1 < x2) ? x1 : x2;
  assign bx2    = (x1 < x2) ? x2 : x1;
  assign by1    = (y1 < y2) ? y1 : y2;
  assign by2    = (y1 < y2) ? y2 : y1;
  assign reject = (cl > bx2) || (cr < bx1) || (ct > by2) || (cb < by1);
  assign dx     = x2 - x1;
  assign dy     = y2 - y1;
  assign xneg   = dx[EXT_WIDTH-1];
  assign yneg   = dy[EXT_WIDTH-1];
  assign dx_mag = xneg ? -dx : dx;
  assign dy_mag = yneg ? -dy : dy;
  assign adx    = dx_mag[COORD_WIDTH-1:0];
  assign ady    = dy_mag[COORD_WIDTH-1:0];
  assign x_major = adx > ady;

  // step: current pixel and error update
  assign px     = axis_swapped_r ? minor_pos_r : major_pos_r;
  assign py     = axis_swapped_r ? major_pos_r : minor_pos_r;
  assign pxe    = EXT_WIDTH'(px);
  assign pye    = EXT_WIDTH'(py);
  assign in_clip = !((pxe < cl) || (cr < pxe) || (pye < ct) || (cb < pye));
  assign fin    = (major_pos_r == major_end_r);

  assign delta_ext     = $signed({{(ERR_WIDTH-COORD_WIDTH){1'b0}}, major_delta_r});
  assign err_sum       = error_acc_r
                         + $signed({{(ERR_WIDTH-COORD_WIDTH-1){1'b0}}, minor_delta_twice_r});
  assign minor_move    = (err_sum >= delta_ext);
  assign error_acc_nxt = minor_move ? (err_sum - (delta_ext <<< 1)) : err_sum;
  assign major_pos_nxt = major_dir_neg_r ? (major_pos_r - COORD_WIDTH'(1))
                                         : (major_pos_r + COORD_WIDTH'(1));
  assign minor_pos_nxt = !minor_move ? minor_pos_r
                       : (minor_dir_neg_r ? (minor_pos_r - COORD_WIDTH'(1))
                                          : (minor_pos_r + COORD_WIDTH'(1)));

  always_comb begin
    part = '0;
    if (item.req_type == REQ_START) begin
      part.status = reject ? ST_REJECT : ST_ACCEPT;
    end else if (!busy_r) begin
      part.status = ST_IDLE;
    end else begin
      part.status  = ST_PIXEL;
      part.px      = px;
      part.py      = py;
      part.color   = held_color_r;
      part.in_clip = in_clip;
      part.fin     = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (adv) begin
      if (item.req_type == REQ_START) begin
        busy_r <= !reject;
      end else if (busy_r && fin) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (item.req_type == REQ_START) begin
        if (!reject) begin
          axis_swapped_r      <= !x_major;
          major_pos_r         <= x_major ? item.x_start : item.y_start;
          minor_pos_r         <= x_major ? item.y_start : item.x_start;
          major_end_r         <= x_major ? item.x_end : item.y_end;
          major_delta_r       <= x_major ? adx : ady;
          minor_delta_twice_r <= x_major ? {ady, 1'b0} : {adx, 1'b0};
          major_dir_neg_r     <= x_major ? xneg : yneg;
          minor_dir_neg_r     <= x_major ? yneg : xneg;
          error_acc_r         <= '0;
          held_color_r        <= item.line_color;
        end
      end else if (busy_r && !fin) begin
        major_pos_r <= major_pos_nxt;
        minor_pos_r <= minor_pos_nxt;
        error_acc_r <= error_acc_nxt;
      end
    end
  end

  // error term stays within [-dmajor, dmajor] for a live line
  `CLR_ASSERT_IMPL(a_err_bound, busy_r, (error_acc_r <= delta_ext) && (error_acc_r >= -delta_ext))
  `CLR_ASSERT_IMPL(a_minor_even, busy_r, !minor_delta_twice_r[0])
  `CLR_ASSERT_NEXT(a_end_idle, adv && (item.req_type == REQ_STEP) && busy_r && fin, !busy_r)

endmodule

`default_nettype wire

### rtl/clipped_line_rasterizer_top.sv
// Pipeline: input reg -> line reg -> output reg (a_item_r, b_part_r, out_item_r).
// One item per cycle unless stalled; a step's state update is a single add-compare.
// in_ready drops only when all three stages hold items and out_ready is low.
// Reset: clip bounds go to 0/0/1023/767, no line is active, pipeline is empty.
`default_nettype none
`include "clipped_line_rasterizer_top_assert.svh"

module clipped_line_rasterizer_top import clr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  clip_t     clip_r;
  logic      a_valid_r, b_valid_r, out_valid_r;
  in_item_t  a_item_r;
  part_t     b_part_r, part;
  out_item_t out_item_r, out_nxt;
  logic      c_en, b_en, adv;

  logic signed [CLIP_WIDTH+1:0] wdiff, wabs;
  logic [CLIP_WIDTH:0]          width;
  logic [OFS_WIDTH:0]           prod, ofs_sum;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r.left   <= CLIP_WIDTH'(0);
      clip_r.top    <= CLIP_WIDTH'(0);
      clip_r.right  <= CLIP_WIDTH'(1023);
      clip_r.bottom <= CLIP_WIDTH'(767);
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_CLIP_LEFT:   clip_r.left   <= pwdata[CLIP_WIDTH-1:0];
        REG_CLIP_TOP:    clip_r.top    <= pwdata[CLIP_WIDTH-1:0];
        REG_CLIP_RIGHT:  clip_r.right  <= pwdata[CLIP_WIDTH-1:0];
        REG_CLIP_BOTTOM: clip_r.bottom <= pwdata[CLIP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CLIP_LEFT:   prdata = {{(32-CLIP_WIDTH){1'b0}}, clip_r.left};
      REG_CLIP_TOP:    prdata = {{(32-CLIP_WIDTH){1'b0}}, clip_r.top};
      REG_CLIP_RIGHT:  prdata = {{(32-CLIP_WIDTH){1'b0}}, clip_r.right};
      REG_CLIP_BOTTOM: prdata = {{(32-CLIP_WIDTH){1'b0}}, clip_r.bottom};
      default:         prdata = '0;
    endcase
  end

  // pipeline flow: each stage moves when the next one is empty or moving
  assign c_en     = !out_valid_r || out_ready;
  assign b_en     = !b_valid_r || c_en;
  assign adv      = a_valid_r && b_en;
  assign in_ready = !a_valid_r || b_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) a_valid_r   <= in_valid;
      if (b_en)     b_valid_r   <= a_valid_r;
      if (c_en)     out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) a_item_r <= in_item;
    if (adv) b_part_r <= part;
    if (c_en && b_valid_r) out_item_r <= out_nxt;
  end

  clr_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (a_item_r),
    .clip  (clip_r),
    .part  (part)
  );

  // offset = |right - left + 1| * y + x; coordinates are within 0..4095 when inside
  assign wdiff   = $signed({2'b00, clip_r.right}) - $signed({2'b00, clip_r.left})
                   + (CLIP_WIDTH+2)'(1);
  assign wabs    = wdiff[CLIP_WIDTH+1] ? -wdiff : wdiff;
  assign width   = wabs[CLIP_WIDTH:0];
  assign prod    = {{(OFS_WIDTH-CLIP_WIDTH){1'b0}}, width}
                   * {{(OFS_WIDTH-CLIP_WIDTH+1){1'b0}}, b_part_r.py[CLIP_WIDTH-1:0]};
  assign ofs_sum = prod + {{(OFS_WIDTH-CLIP_WIDTH+1){1'b0}}, b_part_r.px[CLIP_WIDTH-1:0]};

  always_comb begin
    out_nxt              = '0;
    out_nxt.status       = b_part_r.status;
    out_nxt.pixel_x      = b_part_r.px;
    out_nxt.pixel_y      = b_part_r.py;
    out_nxt.pixel_offset = b_part_r.in_clip ? ofs_sum[OFS_WIDTH-1:0] : '0;
    out_nxt.pixel_color  = b_part_r.color;
    out_nxt.write_enable = b_part_r.in_clip;
    out_nxt.last         = b_part_r.fin;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `CLR_ASSERT_IMPL(a_stall_full, !in_ready, a_valid_r && b_valid_r && out_valid_r && !out_ready)
  `CLR_ASSERT_NEXT(a_b_to_out, b_valid_r && c_en, out_valid_r)
  `CLR_ASSERT_IMPL(a_we_pixel, out_valid_r && out_item_r.write_enable, out_item_r.status == ST_PIXEL)

endmodule

`default_nettype wire

### verif/clipped_line_rasterizer_top_tb.sv
`default_nettype none

module clipped_line_rasterizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clr_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int PHASE_ITEMS  = 270;
  localparam int HOLD_CYCLES  = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  clipped_line_rasterizer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // clip window as the block should hold it
  int win_left = 0;
  int win_top = 0;
  int win_right = 1023;
  int win_bottom = 767;

  // line walker state
  bit          line_active = 1'b0;
  int          major_at = 0;
  int          minor_at = 0;
  int          major_stop = 0;
  int          major_span = 0;
  int          minor_span2 = 0;
  int          err_acc = 0;
  bit          major_back = 1'b0;
  bit          minor_back = 1'b0;
  bit          y_major = 1'b0;
  logic [15:0] line_rgb = '0;

  out_item_t pending_results[$];
  bit        failed = 1'b0;
  int        cycle_count = 0;
  int        burst_left = 0;
  bit        hold_pending = 1'b0;
  int        hold_left = 0;
  int        rx_cycle = 0;

  typedef struct {
    logic    kind;
    int      xs;
    int      ys;
    int      xe;
    int      ye;
    int      color;
    bit      typed;
    status_t st;
  } row_t;

  row_t directed[$];

  function automatic out_item_t rasterize_request(in_item_t rq);
    out_item_t r;
    int        x1, y1, x2, y2, dx, dy, px, py, w;
    int        bx_lo, bx_hi, by_lo, by_hi;
    bit        x_back, y_back, in_clip;
    longint    ofs;
    r = '0;
    if (rq.req_type == REQ_START) begin
      x1 = $signed(rq.x_start);
      y1 = $signed(rq.y_start);
      x2 = $signed(rq.x_end);
      y2 = $signed(rq.y_end);
      bx_lo = (x1 < x2) ? x1 : x2;
      bx_hi = (x1 < x2) ? x2 : x1;
      by_lo = (y1 < y2) ? y1 : y2;
      by_hi = (y1 < y2) ? y2 : y1;
      dx = x2 - x1;
      dy = y2 - y1;
      x_back = dx < 0;
      y_back = dy < 0;
      if (win_left > bx_hi || win_right < bx_lo || win_top > by_hi || win_bottom < by_lo) begin
        line_active = 1'b0;
        r.status = ST_REJECT;
        return r;
      end
      if (x_back) dx = -dx;
      if (y_back) dy = -dy;
      if (dx > dy) begin
        y_major = 1'b0;
        major_at = x1;
        minor_at = y1;
        major_stop = x2;
        major_span = dx;
        minor_span2 = 2 * dy;
        major_back = x_back;
        minor_back = y_back;
      end else begin
        y_major = 1'b1;
        major_at = y1;
        minor_at = x1;
        major_stop = y2;
        major_span = dy;
        minor_span2 = 2 * dx;
        major_back = y_back;
        minor_back = x_back;
      end
      err_acc = 0;
      line_rgb = rq.line_color;
      line_active = 1'b1;
      r.status = ST_ACCEPT;
      return r;
    end
    if (!line_active) begin
      r.status = ST_IDLE;
      return r;
    end
    px = y_major ? minor_at : major_at;
    py = y_major ? major_at : minor_at;
    in_clip = !(px < win_left || win_right < px || py < win_top || win_bottom < py);
    r.status = ST_PIXEL;
    r.pixel_x = 16'(px);
    r.pixel_y = 16'(py);
    if (in_clip) begin
      w = win_right - win_left + 1;
      if (w < 0) w = -w;
      ofs = longint'(w) * longint'(py) + longint'(px);
      r.pixel_offset = ofs[23:0];
    end
    r.pixel_color = line_rgb;
    r.write_enable = in_clip;
    r.last = (major_at == major_stop);
    if (r.last) begin
      line_active = 1'b0;
    end else begin
      major_at += major_back ? -1 : 1;
      err_acc += minor_span2;
      if (err_acc >= major_span) begin
        minor_at += minor_back ? -1 : 1;
        err_acc -= 2 * major_span;
      end
    end
    return r;
  endfunction

  function automatic in_item_t make_req(logic kind, int xs, int ys, int xe, int ye, int color);
    in_item_t it;
    it.req_type = kind;
    it.x_start = 16'(xs);
    it.y_start = 16'(ys);
    it.x_end = 16'(xe);
    it.y_end = 16'(ye);
    it.line_color = 16'(color);
    return it;
  endfunction

  task automatic check_result(out_item_t want, out_item_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      failed = 1'b1;
    end
    if (got.pixel_x !== want.pixel_x) begin
      $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
      failed = 1'b1;
    end
    if (got.pixel_y !== want.pixel_y) begin
      $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
      failed = 1'b1;
    end
    if (got.pixel_offset !== want.pixel_offset) begin
      $error("pixel_offset: expected %0d, got %0d", want.pixel_offset, got.pixel_offset);
      failed = 1'b1;
    end
    if (got.pixel_color !== want.pixel_color) begin
      $error("pixel_color: expected %h, got %h", want.pixel_color, got.pixel_color);
      failed = 1'b1;
    end
    if (got.write_enable !== want.write_enable) begin
      $error("write_enable: expected %b, got %b", want.write_enable, got.write_enable);
      failed = 1'b1;
    end
    if (got.last !== want.last) begin
      $error("last: expected %b, got %b", want.last, got.last);
      failed = 1'b1;
    end
  endtask

  // called right after a rising edge; returns at the edge that accepts the item
  task automatic send_item(in_item_t it, bit typed, status_t st);
    out_item_t want;
    int        gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    want = rasterize_request(it);
    if (typed) begin
      want = '0;
      want.status = st;
    end
    pending_results.push_back(want);
  endtask

  task automatic random_lines(int target);
    int sent, choice, lo_x, hi_x, lo_y, hi_y, x1, y1, dx, dy, span, steps, k;
    sent = 0;
    lo_x = (win_left < win_right) ? win_left : win_right;
    hi_x = (win_left < win_right) ? win_right : win_left;
    lo_y = (win_top < win_bottom) ? win_top : win_bottom;
    hi_y = (win_top < win_bottom) ? win_bottom : win_top;
    while (sent < target) begin
      choice = $urandom_range(0, 9);
      if (choice == 0) begin
        // full-range endpoints: mostly rejected or very long lines
        send_item(make_req(REQ_START, $urandom, $urandom, $urandom, $urandom, $urandom),
                  1'b0, ST_IDLE);
        sent++;
        steps = $urandom_range(0, 3);
      end else if (choice == 1) begin
        steps = 1;
      end else begin
        x1 = lo_x - 20 + int'($urandom_range(0, hi_x - lo_x + 40));
        y1 = lo_y - 20 + int'($urandom_range(0, hi_y - lo_y + 40));
        span = ($urandom_range(0, 7) == 0) ? 200 : 24;
        dx = $urandom_range(0, span);
        dy = $urandom_range(0, span);
        if ($urandom_range(0, 1)) dx = -dx;
        if ($urandom_range(0, 1)) dy = -dy;
        send_item(make_req(REQ_START, x1, y1, x1 + dx, y1 + dy, $urandom), 1'b0, ST_IDLE);
        sent++;
        steps = ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                           : (dy < 0 ? -dy : dy)) + 1;
        case ($urandom_range(0, 7))
          0: steps = $urandom_range(0, steps - 1);  // cut short, next start abandons it
          1: steps += $urandom_range(1, 2);         // run past the end
          default: ;
        endcase
      end
      for (k = 0; k < steps; k++) begin
        send_item(make_req(REQ_STEP, $urandom, $urandom, $urandom, $urandom, $urandom),
                  1'b0, ST_IDLE);
        sent++;
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_clip(logic [1:0] idx, int val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CLIP_LEFT:   win_left = val & 12'hFFF;
      REG_CLIP_TOP:    win_top = val & 12'hFFF;
      REG_CLIP_RIGHT:  win_right = val & 12'hFFF;
      REG_CLIP_BOTTOM: win_bottom = val & 12'hFFF;
      default: ;
    endcase
  endtask

  task automatic set_clip(int l, int t, int r, int b);
    write_clip(REG_CLIP_LEFT, l);
    write_clip(REG_CLIP_TOP, t);
    write_clip(REG_CLIP_RIGHT, r);
    write_clip(REG_CLIP_BOTTOM, b);
    repeat (2) @(posedge clk);
  endtask

  // receiver: rotating ready patterns, plus one long hold on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 64) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
    rx_cycle++;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with nothing expected: status %0d", out_item.status);
        failed = 1'b1;
      end else begin
        check_result(pending_results.pop_front(), out_item);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("clipped_line_rasterizer_top: mismatch");
      $finish;
    end
  end

  initial begin
    int i;
    directed.push_back('{REQ_STEP, 0, 0, 0, 0, 0, 1'b1, ST_IDLE});
    directed.push_back('{REQ_START, -32768, -32768, 32767, 32767, 16'hFFFF, 1'b1, ST_ACCEPT});
    directed.push_back('{REQ_STEP, 0, 0, 0, 0, 0, 1'b0, ST_IDLE});
    directed.push_back('{REQ_STEP, 0, 0, 0, 0, 0, 1'b0, ST_IDLE});
    directed.push_back('{REQ_START, 32767, -32768, -32768, 32767, 0, 1'b1, ST_ACCEPT});
    directed.push_back('{REQ_STEP, 0, 0, 0, 0, 0, 1'b0, ST_IDLE});
    directed.push_back('{REQ_START, -100, 10, -1, 20, 16'h00F0, 1'b1, ST_REJECT});
    directed.push_back('{REQ_STEP, 0, 0, 0, 0, 0, 1'b1, ST_IDLE});
    directed.push_back('{REQ_START, 1030, 0, 2000, 5, 16'h0F00, 1'b1, ST_REJECT});
    directed.push_back('{REQ_START, 0, -50, 10, -1, 16'h0F00, 1'b1, ST_REJECT});
    directed.push_back('{REQ_START, 0, 800, 5, 900, 16'h0F00, 1'b1, ST_REJECT});
    // single-point line: one pixel with last, then idle
    directed.push_back('{REQ_START, 5, 5, 5, 5, 16'h1234, 1'b1, ST_ACCEPT});
    directed.push_back('{REQ_STEP, 0, 0, 0, 0, 0, 1'b0, ST_IDLE});
    directed.push_back('{REQ_STEP, 0, 0, 0, 0, 0, 1'b1, ST_IDLE});
    directed.push_back('{REQ_START, 0, 0, 6, 2, 16'hA5A5, 1'b1, ST_ACCEPT});
    directed.push_back('{REQ_STEP, 0, 0, 0, 0, 0, 1'b0, ST_IDLE});
    directed.push_back('{REQ_STEP, 0, 0, 0, 0, 0, 1'b0, ST_IDLE});
    directed.push_back('{REQ_STEP, 0, 0, 0, 0, 0, 1'b0, ST_IDLE});
    // new start abandons the line in flight
    directed.push_back('{REQ_START, 20, 20, 17, 10, 16'h5A5A, 1'b1, ST_ACCEPT});
    directed.push_back('{REQ_STEP, 0, 0, 0, 0, 0, 1'b0, ST_IDLE});
    directed.push_back('{REQ_STEP, 0, 0, 0, 0, 0, 1'b0, ST_IDLE});
    // diagonal tie crossing the clip corner
    directed.push_back('{REQ_START, 1021, 765, 1024, 768, 16'h7777, 1'b1, ST_ACCEPT});
    directed.push_back('{REQ_STEP, 0, 0, 0, 0, 0, 1'b0, ST_IDLE});
    directed.push_back('{REQ_STEP, 0, 0, 0, 0, 0, 1'b0, ST_IDLE});
    directed.push_back('{REQ_STEP, 0, 0, 0, 0, 0, 1'b0, ST_IDLE});
    directed.push_back('{REQ_STEP, 0, 0, 0, 0, 0, 1'b0, ST_IDLE});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < directed.size(); i++) begin
      send_item(make_req(directed[i].kind, directed[i].xs, directed[i].ys,
                         directed[i].xe, directed[i].ye, directed[i].color),
                directed[i].typed, directed[i].st);
    end
    random_lines(PHASE_ITEMS);
    drain();

    set_clip(0, 0, 4095, 4095);
    // long output stall with the sender kept busy so the pipeline backs up
    hold_pending = 1'b1;
    burst_left = 150;
    random_lines(PHASE_ITEMS);
    drain();

    set_clip(4095, 4095, 0, 0);
    random_lines(PHASE_ITEMS);
    drain();

    set_clip(100, 50, 163, 97);
    random_lines(PHASE_ITEMS);
    drain();

    set_clip($urandom_range(0, 4095), $urandom_range(0, 4095),
             $urandom_range(0, 4095), $urandom_range(0, 4095));
    random_lines(PHASE_ITEMS);
    drain();

    set_clip(0, 0, 0, 0);
    random_lines(PHASE_ITEMS);
    drain();

    if (!failed) begin
      $display("clipped_line_rasterizer_top: match");
    end else begin
      $display("clipped_line_rasterizer_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
